/* src/trimmed_mean_adc_filter_assert.svh */
// Assertion helpers shared by the filter's modules.
`ifndef TRIMMED_MEAN_ADC_FILTER_ASSERT_SVH
`define TRIMMED_MEAN_ADC_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMAF_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("filter assertion failed");

// Next-cycle implication, checked outside reset.
`define TMAF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("filter assertion failed");

`endif

/* src/tmaf_pkg.sv */
`default_nettype none

package tmaf_pkg;

  // Fixed field widths of the sample and channel ports.
  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 3;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;

  // How the back end has to treat a queued command.
  typedef enum logic [1:0] {
    CMD_NONE,   // channel out of range: report zero, no state change
    CMD_FILL,   // window still filling: store sample, report zero
    CMD_SLIDE   // window full: replace oldest, compute trimmed mean
  } cmd_kind_t;

  localparam int KIND_W = $bits(cmd_kind_t);

endpackage

`default_nettype wire

/* src/trimmed_mean_adc_filter.sv */
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// in_      | input     | in_valid/in_stall   | in_channel, in_sample
// out_     | output    | out_valid/out_stall | out_result_channel, out_filtered, out_ready_res
//
// Every input transfer produces exactly one output transfer, in order.
// An out-of-range or still-filling sample goes through the queue to the result register.
// For a full-window sample the back end writes the sample, then
// reads the window through the single read port of its sample memory one entry per
// cycle, then runs the reciprocal divide and its correction in S_DIV0, S_DIV1 and S_FIX.
// Reset (rst_n low, synchronous) empties the queue and output register and clears
// every channel's fill level; window memory contents are written before they are read.
// A two-entry queue parts front and back; an output stall holds the result register.
`default_nettype none

module trimmed_mean_adc_filter import tmaf_pkg::*; #(
  parameter int CHANNELS = 6,
  parameter int WINDOW   = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CHAN_W-1:0]   in_channel,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CHAN_W-1:0]        out_result_channel,
  output logic [SAMPLE_W-1:0]      out_filtered,
  output logic                     out_ready_res
);

  localparam int ADDR_W = $clog2(CHANNELS*WINDOW);
  localparam int CMD_W  = KIND_W + CHAN_W + SAMPLE_W + 2 * ADDR_W;

  logic              push_valid;
  logic              push_ok;
  cmd_kind_t         f_kind;
  logic [CHAN_W-1:0] f_channel;
  logic [SAMPLE_W-1:0] f_sample;
  logic [ADDR_W-1:0] f_addr;
  logic [ADDR_W-1:0] f_base;
  logic [CMD_W-1:0]  push_data;
  logic [CMD_W-1:0]  pop_data;
  logic              q_valid;
  logic              q_pop;

  // Front end: classify the sample and track per-channel window position.
  tmaf_front #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .push_valid  (push_valid),
    .push_ok     (push_ok),
    .cmd_kind    (f_kind),
    .cmd_channel (f_channel),
    .cmd_sample  (f_sample),
    .cmd_addr    (f_addr),
    .cmd_base    (f_base)
  );

  // Command queue between the two ends.
  assign push_data = {f_kind, f_channel, f_sample, f_addr, f_base};

  tmaf_fifo #(
    .DATA_W (CMD_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ok    (push_ok),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (pop_data)
  );

  // Back end: window memory, trimmed mean and result register.
  tmaf_back #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_kind             (cmd_kind_t'(pop_data[CMD_W-1 -: KIND_W])),
    .q_channel          (pop_data[CMD_W-KIND_W-1 -: CHAN_W]),
    .q_sample           (pop_data[2*ADDR_W+SAMPLE_W-1 -: SAMPLE_W]),
    .q_addr             (pop_data[2*ADDR_W-1 -: ADDR_W]),
    .q_base             (pop_data[ADDR_W-1:0]),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_channel (out_result_channel),
    .out_filtered       (out_filtered),
    .out_ready_res      (out_ready_res)
  );

endmodule

`default_nettype wire

/* src/tmaf_front.sv */
`default_nettype none

module tmaf_front import tmaf_pkg::*; #(
  parameter int CHANNELS = 6,
  parameter int WINDOW   = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [CHAN_W-1:0]                   in_channel,
  input  wire logic [SAMPLE_W-1:0]                 in_sample,
  output logic                                     push_valid,
  input  wire logic                                push_ok,
  output cmd_kind_t                                cmd_kind,
  output logic [CHAN_W-1:0]                        cmd_channel,
  output logic [SAMPLE_W-1:0]                      cmd_sample,
  output logic [$clog2(CHANNELS*WINDOW)-1:0]       cmd_addr,
  output logic [$clog2(CHANNELS*WINDOW)-1:0]       cmd_base
);

  localparam int ADDR_W   = $clog2(CHANNELS*WINDOW);
  localparam int CNT_W    = $clog2(WINDOW+1);
  localparam int HEAD_W   = $clog2(WINDOW);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Per-channel fill level and position of the oldest sample.
  logic [CNT_W-1:0]  fill_r [CHANNELS];
  logic [HEAD_W-1:0] head_r [CHANNELS];

  logic [CH_IDX_W-1:0] ch_idx;
  logic                in_range;
  logic [CNT_W-1:0]    fill_cur;
  logic [HEAD_W-1:0]   head_cur;
  logic                filling;
  logic [CNT_W-1:0]    slot;
  logic                xfer;

  // Classify the incoming sample against its channel's state.
  assign ch_idx   = CH_IDX_W'({1'b0, in_channel});
  assign in_range = {2'b00, in_channel} < 5'(CHANNELS);
  assign fill_cur = fill_r[ch_idx];
  assign head_cur = head_r[ch_idx];
  assign filling  = fill_cur < CNT_W'(WINDOW);
  assign slot     = filling ? fill_cur : CNT_W'(head_cur);

  assign cmd_kind    = !in_range ? CMD_NONE : (filling ? CMD_FILL : CMD_SLIDE);
  assign cmd_channel = in_channel;
  assign cmd_sample  = in_sample;
  assign cmd_base    = ADDR_W'(ch_idx) * ADDR_W'(WINDOW);
  assign cmd_addr    = cmd_base + ADDR_W'(slot);

  // A transfer happens whenever a sample is offered and the queue has room.
  assign push_valid = in_valid;
  assign in_stall   = !push_ok;
  assign xfer       = in_valid && push_ok;

  // Advance the fill level, then the ring position once the window is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fill_r[c] <= '0;
        head_r[c] <= '0;
      end
    end else if (xfer && in_range) begin
      if (filling) begin
        fill_r[ch_idx] <= fill_cur + 1'b1;
      end else if (head_cur == HEAD_W'(WINDOW-1)) begin
        head_r[ch_idx] <= '0;
      end else begin
        head_r[ch_idx] <= head_cur + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/tmaf_fifo.sv */
`default_nettype none

`include "trimmed_mean_adc_filter_assert.svh"

module tmaf_fifo import tmaf_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ok,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data
);

  // Two-entry queue between the front and back ends.
  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ok   = count_r != 2'd2;
  assign pop_valid = count_r != 2'd0;
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && push_ok;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `TMAF_ASSERT_IMPL(a_fifo_count_bounded, clk, rst_n, 1'b1, count_r <= 2'd2)

endmodule

`default_nettype wire

/* src/tmaf_back.sv */
`default_nettype none

`include "trimmed_mean_adc_filter_assert.svh"

module tmaf_back import tmaf_pkg::*; #(
  parameter int CHANNELS = 6,
  parameter int WINDOW   = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  output logic                                q_pop,
  input  wire cmd_kind_t                      q_kind,
  input  wire logic [CHAN_W-1:0]              q_channel,
  input  wire logic [SAMPLE_W-1:0]            q_sample,
  input  wire logic [$clog2(CHANNELS*WINDOW)-1:0] q_addr,
  input  wire logic [$clog2(CHANNELS*WINDOW)-1:0] q_base,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [CHAN_W-1:0]                   out_result_channel,
  output logic [SAMPLE_W-1:0]                 out_filtered,
  output logic                                out_ready_res
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(WINDOW+1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int PROD_W = 2 * SUM_W + 1;
  // Divide by WINDOW-2 as a multiply by a truncated reciprocal plus one fix-up.
  localparam logic [SUM_W-1:0] DIV_C = SUM_W'(WINDOW - 2);
  localparam logic [SUM_W:0]   RECIP = (SUM_W+1)'((1 << SUM_W) / (WINDOW - 2));

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV0,
    S_DIV1,
    S_FIX
  } state_t;

  state_t              state_r, state_nxt;
  logic [CHAN_W-1:0]   ch_r, ch_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                pend_r, pend_nxt;
  logic                first_r, first_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic [SAMPLE_W-1:0] hi_r, hi_nxt;
  logic [SUM_W-1:0]    trim_r, trim_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SUM_W-1:0]    q0_r, q0_nxt;
  logic [SUM_W-1:0]    rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]   out_ch_r, out_ch_nxt;
  logic [SAMPLE_W-1:0] out_filt_r, out_filt_nxt;
  logic                out_rdy_r, out_rdy_nxt;

  // Sample window memory, one registered read port and one write port.
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic                wr_en;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                out_free;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_addr] <= q_sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign rd_addr  = base_r + ADDR_W'(k_r);

  // Sequencer: dispatch queued commands, walk the window, divide, report.
  always_comb begin
    logic [SUM_W-1:0] q_fix;
    q_fix         = '0;
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    base_nxt      = base_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    first_nxt     = first_r;
    sum_nxt       = sum_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    trim_nxt      = trim_r;
    prod_nxt      = prod_r;
    q0_nxt        = q0_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_ch_nxt    = out_ch_r;
    out_filt_nxt  = out_filt_r;
    out_rdy_nxt   = out_rdy_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_kind)
            CMD_SLIDE: begin
              q_pop     = 1'b1;
              wr_en     = 1'b1;
              ch_nxt    = q_channel;
              base_nxt  = q_base;
              k_nxt     = '0;
              pend_nxt  = 1'b0;
              first_nxt = 1'b1;
              state_nxt = S_READ;
            end
            CMD_FILL: begin
              if (out_free) begin
                q_pop         = 1'b1;
                wr_en         = 1'b1;
                out_valid_nxt = 1'b1;
                out_ch_nxt    = q_channel;
                out_filt_nxt  = '0;
                out_rdy_nxt   = 1'b0;
              end
            end
            default: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_ch_nxt    = q_channel;
                out_filt_nxt  = '0;
                out_rdy_nxt   = 1'b0;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // Issue one read per cycle; fold in the data of the previous read.
        if (k_r < CNT_W'(WINDOW)) begin
          rd_en    = 1'b1;
          k_nxt    = k_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            sum_nxt = SUM_W'(rd_data_r);
            lo_nxt  = rd_data_r;
            hi_nxt  = rd_data_r;
          end else begin
            sum_nxt = sum_r + SUM_W'(rd_data_r);
            if (rd_data_r < lo_r) begin
              lo_nxt = rd_data_r;
            end
            if (rd_data_r > hi_r) begin
              hi_nxt = rd_data_r;
            end
          end
          if (k_r == CNT_W'(WINDOW)) begin
            state_nxt = S_DIV0;
          end
        end
      end
      S_DIV0: begin
        trim_nxt  = sum_r - SUM_W'(lo_r) - SUM_W'(hi_r);
        prod_nxt  = PROD_W'(trim_nxt) * PROD_W'(RECIP);
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        // Estimate is low by at most one; keep the remainder for the fix-up.
        q0_nxt    = prod_r[2*SUM_W-1:SUM_W];
        rem_nxt   = trim_r - q0_nxt * DIV_C;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        if (out_free) begin
          q_fix         = (rem_r >= DIV_C) ? q0_r + 1'b1 : q0_r;
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_filt_nxt  = (q_fix > SUM_W'(SAMPLE_MAX)) ? SAMPLE_MAX : q_fix[SAMPLE_W-1:0];
          out_rdy_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      k_r         <= k_nxt;
    end
    ch_r       <= ch_nxt;
    base_r     <= base_nxt;
    sum_r      <= sum_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    trim_r     <= trim_nxt;
    prod_r     <= prod_nxt;
    q0_r       <= q0_nxt;
    rem_r      <= rem_nxt;
    out_ch_r   <= out_ch_nxt;
    out_filt_r <= out_filt_nxt;
    out_rdy_r  <= out_rdy_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_channel = out_ch_r;
  assign out_filtered       = out_filt_r;
  assign out_ready_res      = out_rdy_r;

  `TMAF_ASSERT_IMPL(a_zero_when_not_ready, clk, rst_n, out_valid_r && !out_rdy_r, out_filt_r == '0)
  `TMAF_ASSERT_NEXT(a_slide_enters_read, clk, rst_n, state_r == S_IDLE && q_pop && q_kind == CMD_SLIDE, state_r == S_READ)
  `TMAF_ASSERT_IMPL(a_read_count_bounded, clk, rst_n, state_r == S_READ, k_r <= CNT_W'(WINDOW))

endmodule

`default_nettype wire

/* dv/trimmed_mean_adc_filter_checker.sv */
`default_nettype none

// Watches both channels of the filter, predicts each result from the input
// transfers and compares every output transfer with the oldest prediction.
module trimmed_mean_adc_filter_checker import tmaf_pkg::*; #(
  parameter int CHANNELS = 6,
  parameter int WINDOW   = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic [CHAN_W-1:0]   in_channel,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [CHAN_W-1:0]   out_result_channel,
  input  wire logic [SAMPLE_W-1:0] out_filtered,
  input  wire logic                out_ready_res,
  output int unsigned              fail_count,
  output int unsigned              outstanding
);

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic                ready;
    logic [SAMPLE_W-1:0] value;
  } filter_result_t;

  // Shadow copy of the per-channel windows, fill levels and held averages.
  logic [SAMPLE_W-1:0] window_vals [CHANNELS][WINDOW];
  int unsigned         fill_level  [CHANNELS];
  logic [SAMPLE_W-1:0] held_mean   [CHANNELS];

  filter_result_t awaited_results [$];
  int unsigned    errors = 0;

  // Sum of the window minus one minimum and one maximum, over WINDOW-2,
  // clamped to the sample range.
  function automatic logic [SAMPLE_W-1:0] trimmed_mean_of(input int ch);
    int unsigned sum;
    int unsigned lo;
    int unsigned hi;
    int unsigned avg;
    int unsigned v;
    sum = 0;
    lo  = 32'(window_vals[ch][0]);
    hi  = 32'(window_vals[ch][0]);
    for (int k = 0; k < WINDOW; k++) begin
      v   = 32'(window_vals[ch][k]);
      sum = sum + v;
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    end
    avg = (sum - lo - hi) / (WINDOW - 2);
    if (avg > 32'(SAMPLE_MAX)) avg = 32'(SAMPLE_MAX);
    return avg[SAMPLE_W-1:0];
  endfunction

  // Applies one sample to the shadow state and gives the result it causes.
  task automatic advance_channel(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                                 output filter_result_t res);
    int c;
    c         = int'(ch);
    res.chan  = ch;
    res.ready = 1'b0;
    res.value = '0;
    if (c < CHANNELS) begin
      if (fill_level[c] < WINDOW) begin
        window_vals[c][fill_level[c]] = smp;
        fill_level[c] = fill_level[c] + 1;
        held_mean[c]  = '0;
      end else begin
        for (int k = 0; k < WINDOW - 1; k++) window_vals[c][k] = window_vals[c][k+1];
        window_vals[c][WINDOW-1] = smp;
        held_mean[c] = trimmed_mean_of(c);
        res.ready    = 1'b1;
      end
      res.value = held_mean[c];
    end
  endtask

  // Compare output transfers first; a result can never belong to an input
  // accepted at the same edge.
  always @(posedge clk) begin
    filter_result_t want;
    filter_result_t got;
    if (!rst_n) begin
      awaited_results.delete();
      for (int c = 0; c < CHANNELS; c++) begin
        fill_level[c] = 0;
        held_mean[c]  = '0;
        for (int k = 0; k < WINDOW; k++) window_vals[c][k] = '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        got.chan  = out_result_channel;
        got.ready = out_ready_res;
        got.value = out_filtered;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result transfer chan=%0d filtered=%0d ready=%0b",
                   $realtime, got.chan, got.value, got.ready);
          errors = errors + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got.chan !== want.chan) begin
            $display("%0t: result_channel expected %0d actual %0d",
                     $realtime, want.chan, got.chan);
            errors = errors + 1;
          end
          if (got.value !== want.value) begin
            $display("%0t: filtered on chan %0d expected %0d actual %0d",
                     $realtime, want.chan, want.value, got.value);
            errors = errors + 1;
          end
          if (got.ready !== want.ready) begin
            $display("%0t: ready_res on chan %0d expected %0b actual %0b",
                     $realtime, want.chan, want.ready, got.ready);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_channel(in_channel, in_sample, want);
        awaited_results.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= awaited_results.size();
  end

endmodule

`default_nettype wire

/* dv/tb_trimmed_mean_adc_filter.sv */
`default_nettype none

module tb_trimmed_mean_adc_filter import tmaf_pkg::*; ();

  localparam int          N_CHAN      = 6;
  localparam int          WIN         = 4;
  localparam int          N_DIRECTED  = 20;
  localparam int          N_RANDOM    = 1930;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          HOLD_CYCLES = 400;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CHAN_W-1:0]   in_channel;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  logic                out_stall;
  logic [CHAN_W-1:0]   out_result_channel;
  logic [SAMPLE_W-1:0] out_filtered;
  logic                out_ready_res;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // Written by the sender, read by the receiver process.
  bit long_hold_req;
  bit steady;

  // Directed samples: extremes, alternating bit patterns, completing samples,
  // a window of all maximum values, repeated extremes and out-of-range channels.
  logic [CHAN_W-1:0] dir_chan [N_DIRECTED] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd6, 3'd7, 3'd7, 3'd3
  };
  logic [SAMPLE_W-1:0] dir_sample [N_DIRECTED] = '{
    12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h123, 12'hFFF,
    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
    12'h005, 12'h005, 12'h009, 12'h009, 12'h005,
    12'hFFF, 12'h000, 12'hABC, 12'h800
  };

  trimmed_mean_adc_filter #(
    .CHANNELS(N_CHAN),
    .WINDOW  (WIN)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel        (in_channel),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_channel(out_result_channel),
    .out_filtered      (out_filtered),
    .out_ready_res     (out_ready_res)
  );

  trimmed_mean_adc_filter_checker #(
    .CHANNELS(N_CHAN),
    .WINDOW  (WIN)
  ) filter_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel        (in_channel),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_channel(out_result_channel),
    .out_filtered      (out_filtered),
    .out_ready_res     (out_ready_res),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("trimmed_mean_adc_filter: mismatch");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    bit          hold_taken;
    hold_left  = 0;
    run_left   = 0;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (run_left != 0) begin
        out_stall <= 1'b1;
        run_left = run_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 15) begin
        out_stall <= 1'b1;
        run_left = idle_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one sample and returns at the edge of its transfer, or after the gap.
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                             input int unsigned gap);
    in_valid   <= 1'b1;
    in_channel <= ch;
    in_sample  <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops valid and waits until every predicted result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Sample value: uniform, extreme, a noisy level or a value picked from a few.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] level);
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = int'($urandom_range(0, 4095));
      2: v = $urandom_range(0, 1) ? 4095 : 0;
      3: v = 16 * int'($urandom_range(0, 3));
      default: begin
        v = int'(level) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] level [8];
    logic [CHAN_W-1:0]   ch;
    int unsigned         gap;
    bit                  burst;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_channel    <= '0;
    in_sample     <= '0;
    long_hold_req = 1'b0;
    steady        = 1'b0;
    for (int c = 0; c < 8; c++) level[c] = SAMPLE_W'($urandom_range(0, 4095));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    for (int i = 0; i < N_DIRECTED; i++) begin
      gap = $urandom_range(0, 1) ? 0 : idle_len();
      send_sample(dir_chan[i], dir_sample[i], gap);
    end

    // Random part, with one long receiver hold-off, one full drain and one
    // stretch with no idling on either side.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 500) long_hold_req = 1'b1;
      if (i == 1000) drain_results();
      steady = (i >= 1300 && i < 1500);
      burst  = (i >= 500 && i < 560) || steady;
      if ($urandom_range(0, 99) < 4) ch = CHAN_W'($urandom_range(6, 7));
      else ch = CHAN_W'($urandom_range(0, N_CHAN - 1));
      if ($urandom_range(0, 19) == 0) level[ch] = SAMPLE_W'($urandom_range(0, 4095));
      if (burst || $urandom_range(0, 9) < 6) gap = 0;
      else gap = idle_len();
      send_sample(ch, pick_sample(level[ch]), gap);
    end
    steady = 1'b0;

    // Let the last results out and watch for stray ones.
    drain_results();
    repeat (4 * (WIN + 6)) @(posedge clk);
    if (fail_count == 0) begin
      $display("trimmed_mean_adc_filter: match");
    end else begin
      $display("trimmed_mean_adc_filter: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/tmaf_pkg.sv
src/tmaf_front.sv
src/tmaf_fifo.sv
src/tmaf_back.sv
src/trimmed_mean_adc_filter.sv
dv/trimmed_mean_adc_filter_checker.sv
dv/tb_trimmed_mean_adc_filter.sv
